// ===== rtl/core/periodic_task_tick_scheduler_defines.svh =====
// Assertion macros shared by the scheduler RTL.
// Each macro expects clk and rst in scope of the module that uses it.
`ifndef PERIODIC_TASK_TICK_SCHEDULER_DEFINES_SVH
`define PERIODIC_TASK_TICK_SCHEDULER_DEFINES_SVH

// Property checked at every edge outside reset.
`define PSCHED_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PSCHED_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/psched_pkg.sv =====
// Package for the periodic task tick scheduler: sizes, codes, divider reciprocal, table entry
// type, controller state type and the controller/datapath command and status structs. No dependencies.
package psched_pkg;

  localparam int MAX_TASKS = 16;
  localparam int TICK_MS   = 10;

  localparam int OP_W      = 2;
  localparam int MS_W      = 32;
  localparam int STATUS_W  = 2;
  localparam int ID_W      = 4;
  localparam int DELAY_W   = 29;
  localparam int RUNS_W    = 8;

  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W = $clog2(MAX_TASKS + 1);

  // x / TICK_MS == (x * DIV_MAGIC) >> DIV_SHIFT for every MS_W-bit x
  localparam int DIV_SHIFT   = MS_W + $clog2(TICK_MS);
  localparam int DIV_MAGIC_W = MS_W + 1;
  localparam logic [DIV_MAGIC_W-1:0] DIV_MAGIC =
    DIV_MAGIC_W'(((64'd1 << DIV_SHIFT) / 64'(TICK_MS)) + 64'd1);

  localparam logic [OP_W-1:0] OP_CLEAR    = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD      = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK     = 2'd2;
  localparam logic [OP_W-1:0] OP_DISPATCH = 2'd3;

  localparam logic [STATUS_W-1:0] STAT_ADDED = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_DUE   = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_NONE  = 2'd3;

  typedef struct packed {
    logic [DELAY_W-1:0] delay;
    logic [DELAY_W-1:0] period;
    logic [RUNS_W-1:0]  runs;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_ADD,
    S_READ,
    S_UPDATE,
    S_REPLY
  } state_t;

  typedef struct packed {
    logic                clear;
    logic                div_start;
    logic                add_wr;
    logic                idx_clr;
    logic                idx_inc;
    logic                rd_en;
    logic                upd_wr;
    logic                dispatch;
    logic                emit;
    logic [STATUS_W-1:0] emit_status;
  } ctl_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic full;
    logic due_any;
    logic div_done;
    logic last_entry;
    logic entry_due;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== rtl/core/psched_cmd_if.sv =====
// Input channel of the scheduler: valid/ready handshake with op and times.
// Depends on psched_pkg.
interface psched_cmd_if;
  import psched_pkg::*;

  logic            valid;
  logic            ready;
  logic [OP_W-1:0] op;
  logic [MS_W-1:0] delay_ms;
  logic [MS_W-1:0] period_ms;

  modport source (output valid, output op, output delay_ms, output period_ms, input ready);
  modport sink (input valid, input op, input delay_ms, input period_ms, output ready);
endinterface

// ===== rtl/core/psched_rsp_if.sv =====
// Result channel of the scheduler: valid/ready handshake with status, id, last.
// Depends on psched_pkg.
interface psched_rsp_if;
  import psched_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]     task_id;
  logic                last;

  modport source (output valid, output status, output task_id, output last, input ready);
  modport sink (input valid, input status, input task_id, input last, output ready);
endinterface

// ===== rtl/core/psched_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module psched_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== rtl/core/psched_div.sv =====
// Two-lane divider by TICK_MS: each lane multiplies by a rounded-up reciprocal
// and keeps the high product bits. Depends on psched_pkg.
module psched_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [psched_pkg::MS_W-1:0]  dividend_a,
  input  logic [psched_pkg::MS_W-1:0]  dividend_b,
  output logic                         done,
  output logic [psched_pkg::DELAY_W-1:0] quot_a,
  output logic [psched_pkg::DELAY_W-1:0] quot_b
);
  import psched_pkg::*;

  localparam int LANES  = 2;
  localparam int PROD_W = MS_W + DIV_MAGIC_W;

  logic               busy;
  logic [MS_W-1:0]    opnd [LANES];
  logic [PROD_W-1:0]  prod [LANES];
  logic [DELAY_W-1:0] quot [LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      prod[l] = PROD_W'(opnd[l]) * PROD_W'(DIV_MAGIC);
    end
  end

  // capture the operands on start, take the quotients in the following cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      busy <= start;
      done <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      opnd[0] <= dividend_a;
      opnd[1] <= dividend_b;
    end
    if (busy) begin
      for (int l = 0; l < LANES; l++) begin
        quot[l] <= prod[l][DIV_SHIFT +: DELAY_W];
      end
    end
  end

  assign quot_a = quot[0];
  assign quot_b = quot[1];
endmodule

// ===== rtl/core/psched_ctrl.sv =====
// Scheduler controller: accepts transactions and sequences add, tick walk,
// dispatch walk and single replies. Depends on psched_pkg and psched_cmd_if.
`include "periodic_task_tick_scheduler_defines.svh"

module psched_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  psched_cmd_if.sink            cmd,
  output psched_pkg::ctl_cmd_t  ctl,
  input  psched_pkg::dp_stat_t  stat
);
  import psched_pkg::*;

  state_t              state;
  state_t              state_next;
  logic [OP_W-1:0]     op_q;
  logic [OP_W-1:0]     op_q_next;
  logic [STATUS_W-1:0] reply_q;
  logic [STATUS_W-1:0] reply_q_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      op_q    <= OP_CLEAR;
      reply_q <= STAT_NONE;
    end else begin
      state   <= state_next;
      op_q    <= op_q_next;
      reply_q <= reply_q_next;
    end
  end

  always_comb begin
    state_next   = state;
    op_q_next    = op_q;
    reply_q_next = reply_q;
    ctl          = '0;
    cmd.ready    = 1'b0;
    ctl.dispatch = (op_q == OP_DISPATCH);

    case (state)
      S_IDLE: begin
        cmd.ready = 1'b1;
        if (cmd.valid) begin
          op_q_next = cmd.op;
          case (cmd.op)
            OP_CLEAR: begin
              ctl.clear = 1'b1;
            end
            OP_ADD: begin
              if (stat.full) begin
                reply_q_next = STAT_FULL;
                state_next   = S_REPLY;
              end else begin
                ctl.div_start = 1'b1;
                state_next    = S_DIV;
              end
            end
            OP_TICK: begin
              if (!stat.count_zero) begin
                ctl.idx_clr = 1'b1;
                state_next  = S_READ;
              end
            end
            OP_DISPATCH: begin
              if (stat.due_any) begin
                ctl.idx_clr = 1'b1;
                state_next  = S_READ;
              end else begin
                reply_q_next = STAT_NONE;
                state_next   = S_REPLY;
              end
            end
            default: ;
          endcase
        end
      end

      S_DIV: begin
        if (stat.div_done) begin
          state_next = S_ADD;
        end
      end

      S_ADD: begin
        if (stat.out_free) begin
          ctl.add_wr      = 1'b1;
          ctl.emit        = 1'b1;
          ctl.emit_status = STAT_ADDED;
          state_next      = S_IDLE;
        end
      end

      S_READ: begin
        ctl.rd_en  = 1'b1;
        state_next = S_UPDATE;
      end

      S_UPDATE: begin
        // a due entry on dispatch waits here for a free result slot
        if (!(ctl.dispatch && stat.entry_due && !stat.out_free)) begin
          if (!ctl.dispatch) begin
            ctl.upd_wr = 1'b1;
          end else if (stat.entry_due) begin
            ctl.upd_wr      = 1'b1;
            ctl.emit        = 1'b1;
            ctl.emit_status = STAT_DUE;
          end
          if (stat.last_entry) begin
            state_next = S_IDLE;
          end else begin
            ctl.idx_inc = 1'b1;
            state_next  = S_READ;
          end
        end
      end

      S_REPLY: begin
        if (stat.out_free) begin
          ctl.emit        = 1'b1;
          ctl.emit_status = reply_q;
          state_next      = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `PSCHED_ASSERT(a_walk_nonempty, (state == S_READ) |-> !stat.count_zero, "walk on empty table")
  `PSCHED_ASSERT_NEXT(a_div_to_add, (state == S_DIV) && stat.div_done, state == S_ADD, "add lost after divide")
  `PSCHED_ASSERT_NEXT(a_idle_dispatch, cmd.valid && cmd.ready && (cmd.op == OP_DISPATCH) && !stat.due_any, state == S_REPLY, "nothing-due reply missed")
endmodule

// ===== rtl/core/psched_datapath.sv =====
// Scheduler datapath: task table RAM, task count, due flags, walk index,
// divider and result register. Depends on psched_pkg, psched_ram, psched_div, psched_rsp_if.
`include "periodic_task_tick_scheduler_defines.svh"

module psched_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  psched_pkg::ctl_cmd_t          ctl,
  output psched_pkg::dp_stat_t          stat,
  input  logic [psched_pkg::MS_W-1:0]   delay_ms,
  input  logic [psched_pkg::MS_W-1:0]   period_ms,
  psched_rsp_if.source                  rsp
);
  import psched_pkg::*;

  logic [CNT_W-1:0]     count;
  logic [IDX_W-1:0]     idx;
  logic [MAX_TASKS-1:0] due_mask;
  logic [MAX_TASKS-1:0] count_mask;
  logic [MAX_TASKS-1:0] higher_mask;

  logic                 out_valid;
  logic [STATUS_W-1:0]  out_status;
  logic [ID_W-1:0]      out_id;
  logic                 out_last;

  logic                 div_done;
  logic [DELAY_W-1:0]   quot_delay;
  logic [DELAY_W-1:0]   quot_period;

  entry_t               add_entry;
  entry_t               rd_entry;
  entry_t               upd_entry;
  entry_t               wr_entry;
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic                 out_free;

  psched_div u_div (
    .clk        (clk),
    .rst        (rst),
    .start      (ctl.div_start),
    .dividend_a (delay_ms),
    .dividend_b (period_ms),
    .done       (div_done),
    .quot_a     (quot_delay),
    .quot_b     (quot_period)
  );

  psched_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_TASKS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_entry),
    .re    (ctl.rd_en),
    .raddr (idx),
    .rdata (rd_entry)
  );

  always_comb begin
    add_entry.delay  = quot_delay;
    add_entry.period = quot_period;
    add_entry.runs   = '0;

    upd_entry = rd_entry;
    if (ctl.dispatch) begin
      upd_entry.runs = rd_entry.runs - RUNS_W'(1);
    end else if (rd_entry.delay != '0) begin
      upd_entry.delay = rd_entry.delay - DELAY_W'(1);
    end else begin
      // reload and count one more run, holding at the top
      upd_entry.delay = rd_entry.period;
      if (!(&rd_entry.runs)) begin
        upd_entry.runs = rd_entry.runs + RUNS_W'(1);
      end
    end

    ram_we    = ctl.add_wr || ctl.upd_wr;
    ram_waddr = ctl.add_wr ? count[IDX_W-1:0] : idx;
    wr_entry  = ctl.add_wr ? add_entry : upd_entry;

    for (int j = 0; j < MAX_TASKS; j++) begin
      count_mask[j]  = CNT_W'(j) < count;
      higher_mask[j] = (CNT_W'(j) > CNT_W'(idx)) && (CNT_W'(j) < count);
    end
  end

  assign out_free = !out_valid || rsp.ready;

  always_comb begin
    stat.count_zero = (count == '0);
    stat.full       = (count == CNT_W'(MAX_TASKS));
    stat.due_any    = |(due_mask & count_mask);
    stat.div_done   = div_done;
    stat.last_entry = ((CNT_W'(idx) + CNT_W'(1)) == count);
    stat.entry_due  = (rd_entry.runs != '0);
    stat.out_free   = out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      idx      <= '0;
      due_mask <= '0;
    end else begin
      if (ctl.clear) begin
        count <= '0;
      end else if (ctl.add_wr) begin
        count <= count + CNT_W'(1);
      end
      if (ctl.idx_clr) begin
        idx <= '0;
      end else if (ctl.idx_inc) begin
        idx <= idx + IDX_W'(1);
      end
      if (ctl.add_wr) begin
        due_mask[count[IDX_W-1:0]] <= 1'b0;
      end else if (ctl.upd_wr) begin
        due_mask[idx] <= (upd_entry.runs != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.emit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      out_status <= ctl.emit_status;
      case (ctl.emit_status)
        STAT_ADDED: begin
          out_id   <= ID_W'(count);
          out_last <= 1'b1;
        end
        STAT_DUE: begin
          out_id   <= ID_W'(idx);
          out_last <= !(|(due_mask & higher_mask));
        end
        default: begin
          out_id   <= '0;
          out_last <= 1'b1;
        end
      endcase
    end
  end

  assign rsp.valid   = out_valid;
  assign rsp.status  = out_status;
  assign rsp.task_id = out_id;
  assign rsp.last    = out_last;

  `PSCHED_ASSERT(a_emit_free, ctl.emit |-> out_free, "result register overwritten")
  `PSCHED_ASSERT(a_add_room, ctl.add_wr |-> (count < CNT_W'(MAX_TASKS)), "add into full table")
  `PSCHED_ASSERT_NEXT(a_clear_count, ctl.clear, count == '0, "clear left tasks")
endmodule

// ===== rtl/core/periodic_task_tick_scheduler.sv =====
// Periodic task tick scheduler, top level.
// Channel cmd takes a transaction (op, delay_ms, period_ms); channel rsp
// returns results (status, task_id, last), both valid/ready.
// clear: resets the task count, no result. add: the delay and period are
// divided by TICK_MS by reciprocal multiplication in the divider, then the
// S_ADD state writes the entry and registers the result with the new id; a
// table-full result is registered from the S_REPLY state. tick: an S_READ
// state (registered RAM read), then an S_UPDATE state (write back) per table
// entry, no result. dispatch: the same two states per entry, one result per
// due task in index order, last set on the final one; a dispatch with nothing
// due answers with one nothing-due result from the S_REPLY state.
// A new transaction is taken only once the previous one has finished its
// walk.
// Results sit in an output register; while the receiver stalls, the walk
// holds at the next due entry. After reset the table is empty and the block
// is ready at once, with no clearing pass; table entries are only read below
// the task count, all written by an add.
// Depends on psched_pkg, the two channel interfaces, psched_ctrl, psched_datapath.
module periodic_task_tick_scheduler (
  input logic           clk,
  input logic           rst,
  psched_cmd_if.sink    cmd,
  psched_rsp_if.source  rsp
);
  import psched_pkg::*;

  ctl_cmd_t ctl;
  dp_stat_t stat;

  psched_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .ctl  (ctl),
    .stat (stat)
  );

  psched_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .stat      (stat),
    .delay_ms  (cmd.delay_ms),
    .period_ms (cmd.period_ms),
    .rsp       (rsp)
  );
endmodule
